>>> sv/msst_pkg.sv
package msst_pkg;

    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_ADD   = 2'd1;
    localparam logic [1:0] OP_RESET = 2'd2;
    localparam logic [1:0] OP_CLEAR = 2'd3;

    localparam logic [1:0] KIND_FIRED  = 2'd0;
    localparam logic [1:0] KIND_TICK   = 2'd1;
    localparam logic [1:0] KIND_ADD    = 2'd2;
    localparam logic [1:0] KIND_LOOKUP = 2'd3;

    localparam logic [1:0] HSEL_ZERO = 2'd0;
    localparam logic [1:0] HSEL_SLOT = 2'd1;
    localparam logic [1:0] HSEL_NEW  = 2'd2;

    typedef struct packed {
        logic [1:0]  op;
        logic [31:0] amount;
        logic [31:0] period;
        logic        repeat_req;
        logic [31:0] handle_in;
    } t_in;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] handle_out;
        logic        ok;
        logic        last;
    } t_out;

    typedef struct packed {
        logic       capture;
        logic       cnt_inc;
        logic       tick_wr;
        logic       free;
        logic       add_wr;
        logic       lkp_wr;
        logic       emit;
        logic [1:0] kind;
        logic [1:0] hsel;
        logic       ok;
    } t_cmd;

    typedef struct packed {
        logic [1:0] op;
        logic       hzero;
        logic       done;
        logic       present;
        logic       live;
        logic       fire;
        logic       match;
        logic       out_free;
    } t_status;

endpackage

>>> sv/msst_ram.sv
module msst_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

>>> sv/msst_dp.sv
module msst_dp #(
    parameter int SLOTS = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  msst_pkg::t_in    i_in,
    input  msst_pkg::t_cmd   i_cmd,
    output msst_pkg::t_status o_st,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output msst_pkg::t_out   o_out
);

    import msst_pkg::*;

    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW = $clog2(SLOTS + 1);

    t_in              r_in;
    logic [CW-1:0]    r_cnt;
    logic [SLOTS-1:0] r_present;
    logic [SLOTS-1:0] r_active;
    logic [31:0]      r_hcnt;
    logic             r_out_valid;
    t_out             r_out;

    logic [IW-1:0] w_idx;
    logic [31:0]   w_hinc;
    logic [31:0]   w_newh;
    logic [31:0]   w_rem_rd;
    logic [31:0]   w_per_rd;
    logic [31:0]   w_hdl_rd;
    logic          w_rep_rd;
    logic          w_fire;
    logic          w_rem_we;
    logic [31:0]   w_rem_wd;
    logic [31:0]   w_hsel_val;

    assign w_idx  = r_cnt[IW-1:0];
    assign w_hinc = r_hcnt + 32'd1;
    assign w_newh = (w_hinc == 32'd0) ? 32'd1 : w_hinc;
    assign w_fire = r_in.amount >= w_rem_rd;

    // remaining time takes the add period, a reload, or the decremented count
    always_comb begin
        w_rem_we = 1'b0;
        w_rem_wd = r_in.period;
        if (i_cmd.add_wr) begin
            w_rem_we = 1'b1;
        end else if (i_cmd.tick_wr) begin
            if (w_fire) begin
                w_rem_we = w_rep_rd;
                w_rem_wd = w_per_rd;
            end else begin
                w_rem_we = 1'b1;
                w_rem_wd = w_rem_rd - r_in.amount;
            end
        end else if (i_cmd.lkp_wr && r_in.op == OP_RESET) begin
            w_rem_we = 1'b1;
            w_rem_wd = w_per_rd;
        end
    end

    msst_ram #(.WIDTH(32), .DEPTH(SLOTS)) u_rem (
        .i_clk  (i_clk),
        .i_we   (w_rem_we),
        .i_waddr(w_idx),
        .i_wdata(w_rem_wd),
        .i_raddr(w_idx),
        .o_rdata(w_rem_rd)
    );

    msst_ram #(.WIDTH(32), .DEPTH(SLOTS)) u_per (
        .i_clk  (i_clk),
        .i_we   (i_cmd.add_wr),
        .i_waddr(w_idx),
        .i_wdata(r_in.period),
        .i_raddr(w_idx),
        .o_rdata(w_per_rd)
    );

    msst_ram #(.WIDTH(32), .DEPTH(SLOTS)) u_hdl (
        .i_clk  (i_clk),
        .i_we   (i_cmd.add_wr),
        .i_waddr(w_idx),
        .i_wdata(w_newh),
        .i_raddr(w_idx),
        .o_rdata(w_hdl_rd)
    );

    msst_ram #(.WIDTH(1), .DEPTH(SLOTS)) u_rep (
        .i_clk  (i_clk),
        .i_we   (i_cmd.add_wr),
        .i_waddr(w_idx),
        .i_wdata(r_in.repeat_req),
        .i_raddr(w_idx),
        .o_rdata(w_rep_rd)
    );

    always_comb begin
        unique case (i_cmd.hsel)
            HSEL_SLOT: w_hsel_val = w_hdl_rd;
            HSEL_NEW:  w_hsel_val = w_newh;
            default:   w_hsel_val = 32'd0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_in <= i_in;
        end
        if (i_cmd.emit) begin
            r_out.kind       <= i_cmd.kind;
            r_out.handle_out <= w_hsel_val;
            r_out.ok         <= i_cmd.ok;
            r_out.last       <= (i_cmd.kind != KIND_FIRED);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt       <= '0;
            r_present   <= '0;
            r_active    <= '0;
            r_hcnt      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.capture) begin
                r_cnt <= '0;
            end else if (i_cmd.cnt_inc) begin
                r_cnt <= r_cnt + CW'(1);
            end
            if (i_cmd.add_wr) begin
                r_present[w_idx] <= 1'b1;
                r_active[w_idx]  <= 1'b1;
                r_hcnt           <= w_newh;
            end
            if (i_cmd.tick_wr && w_fire && !w_rep_rd) begin
                r_active[w_idx] <= 1'b0;
            end
            if (i_cmd.lkp_wr && r_in.op == OP_CLEAR) begin
                r_active[w_idx] <= 1'b0;
            end
            if (i_cmd.free) begin
                r_present <= r_present & r_active;
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_comb begin
        o_st.op       = r_in.op;
        o_st.hzero    = (r_in.handle_in == 32'd0);
        o_st.done     = (r_cnt == CW'(SLOTS));
        o_st.present  = r_present[w_idx];
        o_st.live     = r_present[w_idx] & r_active[w_idx];
        o_st.fire     = w_fire;
        o_st.match    = (w_hdl_rd == r_in.handle_in);
        o_st.out_free = !r_out_valid || i_out_ready;
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    a_active_in_present: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_active & ~r_present) == '0)
        else $error("active timer without present flag");

    a_add_free_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.add_wr |-> !r_present[w_idx])
        else $error("add overwrote a present slot");

    a_handle_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.add_wr |=> r_hcnt != 32'd0)
        else $error("assigned handle is zero");

endmodule

>>> sv/msst_ctrl.sv
module msst_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  msst_pkg::t_status i_st,
    output msst_pkg::t_cmd    o_cmd
);

    import msst_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DISP   = 3'd1;
    localparam logic [2:0] S_T_CHK  = 3'd2;
    localparam logic [2:0] S_T_EVAL = 3'd3;
    localparam logic [2:0] S_T_END  = 3'd4;
    localparam logic [2:0] S_A_SCAN = 3'd5;
    localparam logic [2:0] S_L_CHK  = 3'd6;
    localparam logic [2:0] S_L_EVAL = 3'd7;

    logic [2:0] r_state;
    logic [2:0] n_state;

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_DISP;
                end
            end
            S_DISP: begin
                unique case (i_st.op)
                    OP_TICK: n_state = S_T_CHK;
                    OP_ADD:  n_state = S_A_SCAN;
                    default: n_state = S_L_CHK;
                endcase
            end
            S_T_CHK: begin
                if (i_st.done) begin
                    n_state = S_T_END;
                end else if (i_st.live) begin
                    n_state = S_T_EVAL;
                end else begin
                    o_cmd.cnt_inc = 1'b1;
                end
            end
            S_T_EVAL: begin
                // hold on a firing timer until the output register is free
                if (!i_st.fire || i_st.out_free) begin
                    o_cmd.tick_wr = 1'b1;
                    o_cmd.cnt_inc = 1'b1;
                    o_cmd.emit    = i_st.fire;
                    o_cmd.kind    = KIND_FIRED;
                    o_cmd.hsel    = HSEL_SLOT;
                    o_cmd.ok      = 1'b1;
                    n_state       = S_T_CHK;
                end
            end
            S_T_END: begin
                if (i_st.out_free) begin
                    o_cmd.free = 1'b1;
                    o_cmd.emit = 1'b1;
                    o_cmd.kind = KIND_TICK;
                    o_cmd.hsel = HSEL_ZERO;
                    o_cmd.ok   = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            S_A_SCAN: begin
                if (i_st.done) begin
                    if (i_st.out_free) begin
                        o_cmd.emit = 1'b1;
                        o_cmd.kind = KIND_ADD;
                        o_cmd.hsel = HSEL_ZERO;
                        o_cmd.ok   = 1'b0;
                        n_state    = S_IDLE;
                    end
                end else if (!i_st.present) begin
                    if (i_st.out_free) begin
                        o_cmd.add_wr = 1'b1;
                        o_cmd.emit   = 1'b1;
                        o_cmd.kind   = KIND_ADD;
                        o_cmd.hsel   = HSEL_NEW;
                        o_cmd.ok     = 1'b1;
                        n_state      = S_IDLE;
                    end
                end else begin
                    o_cmd.cnt_inc = 1'b1;
                end
            end
            S_L_CHK: begin
                if (i_st.done || i_st.hzero) begin
                    if (i_st.out_free) begin
                        o_cmd.emit = 1'b1;
                        o_cmd.kind = KIND_LOOKUP;
                        o_cmd.hsel = HSEL_ZERO;
                        o_cmd.ok   = 1'b0;
                        n_state    = S_IDLE;
                    end
                end else if (i_st.present) begin
                    n_state = S_L_EVAL;
                end else begin
                    o_cmd.cnt_inc = 1'b1;
                end
            end
            S_L_EVAL: begin
                if (i_st.match) begin
                    if (i_st.out_free) begin
                        o_cmd.lkp_wr = 1'b1;
                        o_cmd.emit   = 1'b1;
                        o_cmd.kind   = KIND_LOOKUP;
                        o_cmd.hsel   = HSEL_ZERO;
                        o_cmd.ok     = 1'b1;
                        n_state      = S_IDLE;
                    end
                end else begin
                    o_cmd.cnt_inc = 1'b1;
                    n_state       = S_L_CHK;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.emit |-> i_st.out_free)
        else $error("result issued into a full output register");

    a_last_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.emit && o_cmd.kind != KIND_FIRED) |=> r_state == S_IDLE)
        else $error("closing result not followed by idle");

    a_idle_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !(o_cmd.add_wr || o_cmd.tick_wr || o_cmd.lkp_wr))
        else $error("table written while idle");

endmodule

>>> sv/multi_slot_software_timer_table_top.sv
// Sequence: an item is taken in idle and dispatched, then the slots are swept one per cycle;
// an active slot (tick) or a present slot (reset/clear) takes a check state and an evaluate
// state because of the registered table read. A new item is taken only back in idle; the sweep
// is paced by the single read port of the slot tables; a full output register stalls the sweep.
// Reset: synchronous, active low; clears present and active flags, handle counter and the
// output valid flag. No clearing pass is needed.
module multi_slot_software_timer_table_top #(
    parameter int SLOTS = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  msst_pkg::t_in    i_in,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output msst_pkg::t_out   o_out
);

    import msst_pkg::*;

    t_cmd    w_cmd;
    t_status w_st;

    msst_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_valid(i_in_valid),
        .o_in_ready(o_in_ready),
        .i_st      (w_st),
        .o_cmd     (w_cmd)
    );

    msst_dp #(.SLOTS(SLOTS)) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (i_in),
        .i_cmd      (w_cmd),
        .o_st       (w_st),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out      (o_out)
    );

endmodule
